FILE: rtl/core/bblur_pkg.sv
// Shared types and constants for the 3x3 box blur stream.
// Pixel and result beat layouts, per-channel sum types, register indexes.
// No dependencies.
`default_nettype none

package bblur_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 16;
  localparam int SAMPLE_W     = 8;

  // Configuration register layout
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;
  localparam int CHAN_REG_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST    = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST   = 16'd480;
  localparam logic [CHAN_REG_W-1:0]   CHANNELS_RST = 3'd3;

  // Column sum of three samples, window sum of nine
  localparam int COLSUM_W = SAMPLE_W + 2;
  localparam int WINSUM_W = SAMPLE_W + 4;

  // floor(x / 9) == (x * 7282) >> 16 for every x up to 9 * 255
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int PROD_W      = WINSUM_W + RECIP_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
  } pixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean_0;
    logic [SAMPLE_W-1:0] mean_1;
    logic [SAMPLE_W-1:0] mean_2;
    logic [SAMPLE_W-1:0] mean_3;
    logic [COL_W-1:0]    center_col;
    logic [ROW_W-1:0]    center_row;
    logic                frame_last;
  } result_t;

  // One line buffer entry: the row two above and the row one above
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
  } line_pair_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } lb_req_t;

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lanes_t;
  typedef logic [MAX_CHANNELS-1:0][COLSUM_W-1:0] colsum_t;
  typedef logic [MAX_CHANNELS-1:0][WINSUM_W-1:0] winsum_t;

  function automatic lanes_t lanes(input pixel_t p);
    lanes_t l;
    l[0] = p.sample_0;
    l[1] = p.sample_1;
    l[2] = p.sample_2;
    l[3] = p.sample_3;
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bblur_cell.sv
// One window cell: holds the per-channel sum of one pixel column and adds it
// to the running window sum passed along the chain. Uses bblur_pkg.
`default_nettype none

module bblur_cell (
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire bblur_pkg::colsum_t d,
  output bblur_pkg::colsum_t      q,
  input  wire bblur_pkg::winsum_t sum_in,
  output bblur_pkg::winsum_t      sum_out
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

  always_comb begin
    for (int c = 0; c < bblur_pkg::MAX_CHANNELS; c++) begin
      sum_out[c] = sum_in[c] + bblur_pkg::WINSUM_W'(q[c]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bblur_line_buf.sv
// Line buffer: one entry per column holding the two previous rows.
// One write port, one registered read port. Uses bblur_pkg.
`default_nettype none

module bblur_line_buf (
  input  wire logic                  clk,
  input  wire bblur_pkg::lb_req_t    req,
  input  wire bblur_pkg::line_pair_t wr_data,
  output bblur_pkg::line_pair_t      rd_data
);

  bblur_pkg::line_pair_t mem [bblur_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/box_blur_3x3_stream.sv
// Streaming 3x3 mean filter, top level.
// Uses bblur_pkg, bblur_line_buf and bblur_cell.
//
// Pixels come in on the pixel channel in raster order, one beat per pixel,
// channels 0..3 side by side. Each beat whose column and row are both 2 or
// more completes the 3x3 neighborhood of pixel (col-1, row-1), and one
// result beat follows with the per-channel mean (sum / 9, truncated), the
// center coordinates and frame_last on the last interior pixel. Border
// pixels give no beat; inactive channels read zero.
// Throughput is one pixel per clock while the receiver does not stall. A
// result passes through registers in order: the line buffer read lands in
// stage A, the column sums and the two-cell chain form the window sum into
// stage B, then the multiply by the reciprocal of 9 fills the output register.
// The config port (cfg_valid/cfg_ready, always ready) sets width, height and
// channel count; write it only while the block is idle.
// Reset clears the pipeline, the row/column counters and the registers to
// 640 x 480 x 3. The line buffer has no clearing pass and is filled by the
// first two rows of each frame.
// When the receiver stalls, the output register, stage B and stage A fill in
// turn; pixel_stall is high while all three are full and result_stall is high.
`default_nettype none

module box_blur_3x3_stream (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 pixel_valid,
  output logic                                      pixel_stall,
  input  wire bblur_pkg::pixel_t                    pixel,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output bblur_pkg::result_t                        result,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bblur_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bblur_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COL_W = bblur_pkg::COL_W;
  localparam int ROW_W = bblur_pkg::ROW_W;
  localparam int WW    = bblur_pkg::WIDTH_REG_W;
  localparam int HW    = bblur_pkg::HEIGHT_REG_W;
  localparam int CW    = bblur_pkg::CHAN_REG_W;
  localparam int NCH   = bblur_pkg::MAX_CHANNELS;

  // ---------------- configuration ----------------
  logic [WW-1:0] width_reg;
  logic [HW-1:0] height_reg;
  logic [CW-1:0] chan_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bblur_pkg::WIDTH_RST;
      height_reg <= bblur_pkg::HEIGHT_RST;
      chan_reg   <= bblur_pkg::CHANNELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bblur_pkg::REG_WIDTH:    width_reg  <= cfg_data[WW-1:0];
        bblur_pkg::REG_HEIGHT:   height_reg <= cfg_data[HW-1:0];
        bblur_pkg::REG_CHANNELS: chan_reg   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] eff_ch;

  always_comb begin
    if (width_reg < WW'(3)) begin
      eff_w = WW'(3);
    end else if (width_reg > WW'(bblur_pkg::MAX_WIDTH)) begin
      eff_w = WW'(bblur_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_reg;
    end
    eff_h = (height_reg < HW'(3)) ? HW'(3) : height_reg;
    if (chan_reg < CW'(1)) begin
      eff_ch = CW'(1);
    end else if (chan_reg > CW'(NCH)) begin
      eff_ch = CW'(NCH);
    end else begin
      eff_ch = chan_reg;
    end
  end

  // ---------------- raster counters ----------------
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             end_line;
  logic             end_frame;
  logic             emit;
  logic             take;

  // Pipeline handshake
  logic a_v, b_v;
  logic a_ready, b_ready, out_ready;
  logic a_adv, b_adv;

  assign end_line  = WW'(col_count) >= (eff_w - WW'(1));
  assign end_frame = end_line && (row_count >= (eff_h - HW'(1)));
  assign emit      = (col_count >= COL_W'(2)) && (row_count >= ROW_W'(2));

  assign out_ready   = !result_valid || !result_stall;
  assign b_ready     = !b_v || out_ready;
  assign a_ready     = !a_v || b_ready;
  assign a_adv       = a_v && b_ready;
  assign b_adv       = b_v && out_ready;
  assign pixel_stall = !a_ready;
  assign take        = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (take) begin
      if (end_frame) begin
        col_count <= '0;
        row_count <= '0;
      end else if (end_line) begin
        col_count <= '0;
        row_count <= row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // ---------------- stage A: line buffer read data ----------------
  bblur_pkg::pixel_t   a_cur;
  logic [COL_W-1:0]    a_col;
  logic [ROW_W-1:0]    a_row;
  logic                a_emit;
  logic                a_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (take) begin
      a_v <= 1'b1;
    end else if (a_adv) begin
      a_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_cur  <= pixel;
      a_col  <= col_count;
      a_row  <= row_count;
      a_emit <= emit;
      a_last <= end_frame;
    end
  end

  bblur_pkg::lb_req_t     lb_req;
  bblur_pkg::line_pair_t  lb_wr;
  bblur_pkg::line_pair_t  lb_rd;

  // Write address is the previous beat's column, read address the next one:
  // they never meet since a row ends no earlier than column 2.
  assign lb_req.rd_en   = take;
  assign lb_req.rd_addr = col_count;
  assign lb_req.wr_en   = a_adv;
  assign lb_req.wr_addr = a_col;
  assign lb_wr.top      = lb_rd.mid;
  assign lb_wr.mid      = a_cur;

  bblur_line_buf u_line_buf (
    .clk     (clk),
    .req     (lb_req),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  bblur_pkg::lanes_t  top_l, mid_l, cur_l;
  bblur_pkg::colsum_t col_sum;
  bblur_pkg::winsum_t chain_in;

  always_comb begin
    top_l = bblur_pkg::lanes(lb_rd.top);
    mid_l = bblur_pkg::lanes(lb_rd.mid);
    cur_l = bblur_pkg::lanes(a_cur);
    for (int c = 0; c < NCH; c++) begin
      col_sum[c]  = bblur_pkg::COLSUM_W'(top_l[c]) + bblur_pkg::COLSUM_W'(mid_l[c])
                  + bblur_pkg::COLSUM_W'(cur_l[c]);
      chain_in[c] = bblur_pkg::WINSUM_W'(col_sum[c]);
    end
  end

  // Two cells hold the column sums of columns col-1 and col-2
  bblur_pkg::colsum_t cell0_q, cell1_q;
  bblur_pkg::winsum_t chain_mid, win_sum;

  bblur_cell u_cell0 (
    .clk     (clk),
    .shift   (a_adv),
    .d       (col_sum),
    .q       (cell0_q),
    .sum_in  (chain_in),
    .sum_out (chain_mid)
  );

  bblur_cell u_cell1 (
    .clk     (clk),
    .shift   (a_adv),
    .d       (cell0_q),
    .q       (cell1_q),
    .sum_in  (chain_mid),
    .sum_out (win_sum)
  );

  // ---------------- stage B: window sum ----------------
  bblur_pkg::winsum_t b_sum;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic               b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (a_adv) begin
      b_v <= a_emit;
    end else if (b_adv) begin
      b_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_sum  <= win_sum;
      b_col  <= a_col - COL_W'(1);
      b_row  <= a_row - ROW_W'(1);
      b_last <= a_last;
    end
  end

  // ---------------- output: divide by 9 ----------------
  logic [bblur_pkg::PROD_W-1:0]  prod [NCH];
  logic [NCH-1:0][bblur_pkg::SAMPLE_W-1:0] mean;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] = bblur_pkg::PROD_W'(b_sum[c]) * bblur_pkg::PROD_W'(bblur_pkg::RECIP_9);
      if (CW'(c) < eff_ch) begin
        mean[c] = prod[c][bblur_pkg::RECIP_SHIFT +: bblur_pkg::SAMPLE_W];
      end else begin
        mean[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      result.mean_0     <= mean[0];
      result.mean_1     <= mean[1];
      result.mean_2     <= mean[2];
      result.mean_3     <= mean[3];
      result.center_col <= b_col;
      result.center_row <= b_row;
      result.frame_last <= b_last;
    end
  end

  // ---------------- assertions ----------------
  a_lb_no_collision : assert property (@(posedge clk) disable iff (rst)
    (lb_req.rd_en && lb_req.wr_en) |-> (lb_req.rd_addr != lb_req.wr_addr))
    else $error("line buffer read and write hit the same column");

  a_emit_reaches_b : assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_emit) |=> b_v)
    else $error("interior beat lost between window and divide stage");

  a_center_interior : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.center_col != '0 && result.center_row != '0))
    else $error("result beat carries a border coordinate");

  a_stall_means_full : assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (a_v && b_v && result_valid && result_stall))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

FILE: test/bblur_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the 3x3 box blur stream: watches the pixel, result and register
// channels, predicts every blurred pixel and compares results field by field.
// Depends on bblur_pkg.
module bblur_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  input  logic                                pixel_stall,
  input  bblur_pkg::pixel_t                   pixel,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  bblur_pkg::result_t                  result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  results_seen,
  output logic                                frame_start
);
  import bblur_pkg::*;

  localparam int WINDOW_CELLS = 9;
  localparam int PRINT_CAP    = 100;

  // predicted line store: row two above and row one above, per column
  pixel_t upper_line [MAX_WIDTH];
  pixel_t lower_line [MAX_WIDTH];
  // previous two columns, top/mid/bottom each
  pixel_t win [6];

  logic [COL_W-1:0]        col_pos;
  logic [ROW_W-1:0]        row_pos;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [CHAN_REG_W-1:0]   chan_reg;

  result_t blur_due [$];
  int mismatches = 0;
  int checked    = 0;

  function automatic int unsigned lane_of(input pixel_t p, input int ch);
    case (ch)
      0: return 32'(p.sample_0);
      1: return 32'(p.sample_1);
      2: return 32'(p.sample_2);
      default: return 32'(p.sample_3);
    endcase
  endfunction

  task automatic flag(input string what, input logic [ROW_W-1:0] got_v,
                      input logic [ROW_W-1:0] want_v);
    if (mismatches < PRINT_CAP)
      $display("%0t chk: %s got %0d want %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic fold_pixel(input pixel_t cur);
    int unsigned w, h, nch, acc;
    pixel_t top, mid;
    pixel_t nbr [WINDOW_CELLS];
    logic [SAMPLE_W-1:0] avg [MAX_CHANNELS];
    logic wrap_line, wrap_frame;
    result_t want;
    w = 32'(width_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg < HEIGHT_REG_W'(3)) ? 3 : 32'(height_reg);
    nch = 32'(chan_reg);
    if (nch < 1) nch = 1;
    if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
    top = upper_line[col_pos];
    mid = lower_line[col_pos];
    wrap_line  = 32'(col_pos) >= w - 1;
    wrap_frame = wrap_line && 32'(row_pos) >= h - 1;
    if (col_pos >= COL_W'(2) && row_pos >= ROW_W'(2)) begin
      for (int k = 0; k < 6; k++) nbr[k] = win[k];
      nbr[6] = top;
      nbr[7] = mid;
      nbr[8] = cur;
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
        acc = 0;
        if (ch < nch)
          for (int k = 0; k < WINDOW_CELLS; k++) acc += lane_of(nbr[k], ch);
        avg[ch] = SAMPLE_W'(acc / WINDOW_CELLS);
      end
      want.mean_0     = avg[0];
      want.mean_1     = avg[1];
      want.mean_2     = avg[2];
      want.mean_3     = avg[3];
      want.center_col = col_pos - COL_W'(1);
      want.center_row = row_pos - ROW_W'(1);
      want.frame_last = wrap_frame;
      blur_due.push_back(want);
    end
    upper_line[col_pos] = mid;
    lower_line[col_pos] = cur;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = cur;
    if (wrap_frame) begin
      col_pos = '0;
      row_pos = '0;
    end else if (wrap_line) begin
      col_pos = '0;
      row_pos = row_pos + ROW_W'(1);
    end else begin
      col_pos = col_pos + COL_W'(1);
    end
  endtask

  task automatic match_result(input result_t got);
    result_t want;
    if (blur_due.size() == 0) begin
      flag("result beat with none expected, center_col", ROW_W'(got.center_col), '0);
      return;
    end
    want = blur_due.pop_front();
    checked++;
    if (got.mean_0 !== want.mean_0)
      flag("mean_0", ROW_W'(got.mean_0), ROW_W'(want.mean_0));
    if (got.mean_1 !== want.mean_1)
      flag("mean_1", ROW_W'(got.mean_1), ROW_W'(want.mean_1));
    if (got.mean_2 !== want.mean_2)
      flag("mean_2", ROW_W'(got.mean_2), ROW_W'(want.mean_2));
    if (got.mean_3 !== want.mean_3)
      flag("mean_3", ROW_W'(got.mean_3), ROW_W'(want.mean_3));
    if (got.center_col !== want.center_col)
      flag("center_col", ROW_W'(got.center_col), ROW_W'(want.center_col));
    if (got.center_row !== want.center_row)
      flag("center_row", got.center_row, want.center_row);
    if (got.frame_last !== want.frame_last)
      flag("frame_last", ROW_W'(got.frame_last), ROW_W'(want.frame_last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      blur_due.delete();
      col_pos    = '0;
      row_pos    = '0;
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      chan_reg   = CHANNELS_RST;
      for (int k = 0; k < 6; k++) win[k] = '0;
      for (int k = 0; k < MAX_WIDTH; k++) begin
        upper_line[k] = '0;
        lower_line[k] = '0;
      end
    end else begin
      // result first: a pixel beat on this edge cannot have produced it yet
      if (result_valid && !result_stall) match_result(result);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:    width_reg  = cfg_data[WIDTH_REG_W-1:0];
          REG_HEIGHT:   height_reg = cfg_data[HEIGHT_REG_W-1:0];
          REG_CHANNELS: chan_reg   = cfg_data[CHAN_REG_W-1:0];
          default: ;
        endcase
      end
      if (pixel_valid && !pixel_stall) fold_pixel(pixel);
    end
    errors       <= mismatches;
    pending      <= blur_due.size();
    results_seen <= checked;
    frame_start  <= (col_pos == '0) && (row_pos == '0);
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Top of the box blur testbench: clock, reset, pixel and register stimulus,
// receiver stalls and the verdict. Depends on bblur_pkg, box_blur_3x3_stream
// and bblur_checker.
module tb;
  import bblur_pkg::*;

  localparam int RANDOM_PIXELS = 2000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int LONG_HOLD     = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  pixel_valid  = 1'b0;
  pixel_t                pixel        = '0;
  logic                  result_stall = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  pixel_stall;
  logic                  result_valid;
  result_t               result;
  logic                  cfg_ready;

  int   errors, pending, results_seen;
  logic frame_start;

  int send_idle_pct = 14;
  int recv_idle_pct = 51;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int pixels_sent   = 0;
  int reg_writes    = 0;
  int floor_lvl     = 0;
  int unsigned eff_w = 640;

  box_blur_3x3_stream dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bblur_checker chk (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .frame_start  (frame_start)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: timed out with %0d results outstanding", pending);
    $display("tb: done, errors");
    $finish;
  end

  // receiver: random stalls, plus a long hold whenever the stimulus asks
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic pixel_t noisy_pixel();
    pixel_t p;
    logic [SAMPLE_W-1:0] s [MAX_CHANNELS];
    for (int c = 0; c < MAX_CHANNELS; c++)
      case ($urandom_range(0, 9))
        0: s[c] = '0;
        1: s[c] = '1;
        default: s[c] = SAMPLE_W'($urandom_range(floor_lvl, 255));
      endcase
    p.sample_0 = s[0];
    p.sample_1 = s[1];
    p.sample_2 = s[2];
    p.sample_3 = s[3];
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic push_pixel(input pixel_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      pixel       <= noisy_pixel();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
  endtask

  // sender pauses until every expected beat is back, then lets the pipeline empty
  task automatic drain();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic stream_pixels(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_token++;
      push_pixel(noisy_pixel());
    end
    drain();
  endtask

  initial begin : stimulus
    pixel_t p;
    logic [CFG_IDX_W-1:0]   reg_sel [$];
    logic [CFG_DATA_W-1:0]  reg_val [$];
    logic [WIDTH_REG_W-1:0] wv;
    int rnd_start, done, spins;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // smallest frame, saturated samples, channel count left at its reset value
    write_reg(REG_WIDTH, 16'd3, 1'b1);
    write_reg(REG_HEIGHT, 16'd3, 1'b0);
    eff_w = 3;
    for (int i = 0; i < 9; i++) push_pixel({4{8'hFF}});
    drain();

    // all four channels, one full, one empty, two uneven ramps
    write_reg(REG_CHANNELS, 16'd4, 1'b0);
    for (int i = 0; i < 9; i++) begin
      p.sample_0 = 8'hFF;
      p.sample_1 = 8'h00;
      p.sample_2 = 8'(255 - i * i * 3);
      p.sample_3 = 8'(i * i);
      push_pixel(p);
    end
    drain();

    // registers below range clamp up
    write_reg(REG_WIDTH, 16'd0, 1'b1);
    write_reg(REG_HEIGHT, 16'd2, 1'b1);
    write_reg(REG_CHANNELS, 16'd0, 1'b0);
    stream_pixels(9, -1);

    // channel count above range, then a long receiver hold mid-frame
    write_reg(REG_CHANNELS, 16'hFFFF, 1'b1);
    write_reg(REG_WIDTH, 16'd10, 1'b1);
    write_reg(REG_HEIGHT, 16'd8, 1'b0);
    eff_w = 10;
    stream_pixels(80, 30);

    rnd_start = pixels_sent;
    while (pixels_sent - rnd_start < RANDOM_PIXELS) begin
      done = pixels_sent - rnd_start;
      if (done < RANDOM_PIXELS / 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 51;
      end else if (done < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      reg_sel.delete();
      reg_val.delete();
      if ($urandom_range(0, 1)) begin
        // width may only grow at a frame boundary: wider columns were never stored
        wv = WIDTH_REG_W'(frame_start ? $urandom_range(0, 24) : $urandom_range(0, eff_w));
        eff_w = (wv < WIDTH_REG_W'(3)) ? 3 : 32'(wv);
        reg_sel.push_back(REG_WIDTH);
        reg_val.push_back({4'($urandom), wv});
      end
      if ($urandom_range(0, 1)) begin
        reg_sel.push_back(REG_HEIGHT);
        reg_val.push_back(($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                      : 16'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1)) begin
        reg_sel.push_back(REG_CHANNELS);
        reg_val.push_back(16'($urandom));
      end
      if ($urandom_range(0, 15) == 0) begin
        reg_sel.push_back(REG_UNUSED);
        reg_val.push_back(16'($urandom));
      end
      for (int k = 0; k < reg_sel.size(); k++)
        write_reg(reg_sel[k], reg_val[k], k < reg_sel.size() - 1);
      case ($urandom_range(0, 3))
        0: floor_lvl = 240;
        1: floor_lvl = 128;
        default: floor_lvl = 0;
      endcase
      stream_pixels($urandom_range(1, 160), -1);
    end

    // finish the current frame, then part of a line at the clamped widest setting
    write_reg(REG_HEIGHT, 16'd3, 1'b0);
    while (!frame_start) begin
      push_pixel(noisy_pixel());
      drain();
    end
    write_reg(REG_WIDTH, 16'hFFFF, 1'b1);
    write_reg(REG_CHANNELS, 16'd5, 1'b0);
    eff_w = MAX_WIDTH;
    floor_lvl = 0;
    stream_pixels(MAX_WIDTH / 8, -1);

    spins = 0;
    while (pending != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d pixels streamed, %0d blurred beats checked, %0d register writes",
             pixels_sent, results_seen, reg_writes);
    $display("tb: widths 3..24 plus a clamped widest line, heights up to 65535, %s",
             "clamped registers, stalls both ways");
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches, %0d beats never arrived", errors, pending);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
